// File: rtl/core/mna_stamp_accumulator_defines.svh
// Assertion macros used by the RTL of the stamp accumulator.
`ifndef MNA_STAMP_ACCUMULATOR_DEFINES_SVH
`define MNA_STAMP_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MNA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define MNA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mna_pkg.sv
`default_nettype none

package mna_pkg;

  localparam int DIM    = 64;
  localparam int IDX_W  = $clog2(DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DATA_W = 64;
  localparam int CNT_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] Q_ONE = 64'h0000_0001_0000_0000;
  localparam logic [DATA_W-1:0] Q_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [DATA_W-1:0] Q_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_VSRC   = 3'd1,
    OP_ISRC   = 3'd2,
    OP_IBR    = 3'd3,
    OP_RES    = 3'd4,
    OP_RBR    = 3'd5,
    OP_READ_M = 3'd6,
    OP_READ_R = 3'd7
  } op_t;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_SAT  = 2'd2;

  // Conductance result handed from the reciprocal unit to the top level.
  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DATA_W-1:0] g;
  } recip_res_t;

endpackage

`default_nettype wire

// File: rtl/core/mna_stamp_accumulator.sv
//  channel  direction  handshake             payload
//  s_*      in         s_tvalid / s_tready   op, node_from, node_to, branch_index,
//                                            value, read_row, read_col
//  m_*      out        m_tvalid / m_tready   read_value, status
//
// Items are handled one at a time. A stamp reads each touched entry, then
// adds with saturation and writes it back, for 2 to 5 entries, and loads the
// result; a nonzero resistor in conductance form first waits on the bit-serial
// reciprocal unit. A read fetches the entry, then loads it. A clear and reset
// sweep all 4096 matrix entries, one per cycle, while no item is taken.
// The result waits in an output register, so the next item is taken meanwhile.
`default_nettype none

module mna_stamp_accumulator (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [2:0] op, [8:3] node_from, [14:9] node_to, [20:15] branch_index,
  // [84:21] value, [90:85] read_row, [96:91] read_col, [103:97] zero
  input  wire logic [103:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [63:0] read_value, [65:64] status, [71:66] zero
  output logic      [71:0]  m_tdata
);

  `include "mna_stamp_accumulator_defines.svh"

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_DIV, S_RD, S_WR, S_DONE
  } state_t;

  typedef struct packed {
    logic                        is_rhs;
    logic [mna_pkg::IDX_W-1:0]   row;
    logic [mna_pkg::IDX_W-1:0]   col;
    logic                        sub;
    logic [mna_pkg::DATA_W-1:0]  delta;
  } touch_t;

  state_t                      state;
  mna_pkg::op_t                op;
  logic [mna_pkg::IDX_W-1:0]   nf;
  logic [mna_pkg::IDX_W-1:0]   nt;
  logic [mna_pkg::IDX_W-1:0]   nk;
  logic [mna_pkg::DATA_W-1:0]  val;
  logic [mna_pkg::IDX_W-1:0]   rrow;
  logic [mna_pkg::IDX_W-1:0]   rcol;
  logic [mna_pkg::DATA_W-1:0]  gval;
  logic [2:0]                  step;
  logic                        sat;
  logic                        zero_res;
  logic                        clr_item;
  logic [mna_pkg::ADDR_W-1:0]  clr_cnt;
  logic [mna_pkg::DATA_W-1:0]  rd_val;
  logic [1:0]                  status;

  logic                        s_acc;
  mna_pkg::op_t                in_op;
  logic [mna_pkg::DATA_W-1:0]  in_value;
  logic                        is_read;
  touch_t                      touch;
  logic [2:0]                  last_step;
  logic [mna_pkg::DATA_W-1:0]  cur;
  logic [mna_pkg::DATA_W:0]    sum;
  logic                        ovf;
  logic [mna_pkg::DATA_W-1:0]  upd;
  logic                        recip_start;
  mna_pkg::recip_res_t         recip;

  logic                        mat_we;
  logic [mna_pkg::ADDR_W-1:0]  mat_waddr;
  logic [mna_pkg::ADDR_W-1:0]  mat_raddr;
  logic [mna_pkg::DATA_W-1:0]  mat_rdata;
  logic                        rhs_we;
  logic [mna_pkg::IDX_W-1:0]   rhs_waddr;
  logic [mna_pkg::IDX_W-1:0]   rhs_raddr;
  logic [mna_pkg::DATA_W-1:0]  rhs_rdata;
  logic [mna_pkg::DATA_W-1:0]  wdata;

  assign s_tready = state == S_IDLE;
  assign s_acc    = s_tvalid && s_tready;
  assign in_op    = mna_pkg::op_t'(s_tdata[2:0]);
  assign in_value = s_tdata[84:21];
  assign m_tdata  = {6'd0, status, rd_val};
  assign is_read  = (op == mna_pkg::OP_READ_M) || (op == mna_pkg::OP_READ_R);

  // The entries one stamp touches, in the order they are updated. Entries
  // that coincide are simply updated again on a later step.
  always_comb begin
    touch = '{is_rhs: 1'b0, row: nf, col: nk, sub: 1'b0, delta: mna_pkg::Q_ONE};
    last_step = 3'd4;
    case (op) inside
      mna_pkg::OP_VSRC, mna_pkg::OP_RBR: begin
        case (step)
          3'd0: touch = '{1'b0, nf, nk, 1'b0, mna_pkg::Q_ONE};
          3'd1: touch = '{1'b0, nt, nk, 1'b1, mna_pkg::Q_ONE};
          3'd2: touch = '{1'b0, nk, nf, 1'b0, mna_pkg::Q_ONE};
          3'd3: touch = '{1'b0, nk, nt, 1'b1, mna_pkg::Q_ONE};
          default: begin
            if (op == mna_pkg::OP_VSRC) begin
              touch = '{1'b1, nk, nk, 1'b0, val};
            end else begin
              touch = '{1'b0, nk, nk, 1'b1, val};
            end
          end
        endcase
      end
      mna_pkg::OP_ISRC: begin
        last_step = 3'd1;
        if (step == 3'd0) begin
          touch = '{1'b1, nf, nf, 1'b1, val};
        end else begin
          touch = '{1'b1, nt, nt, 1'b0, val};
        end
      end
      mna_pkg::OP_IBR: begin
        last_step = 3'd3;
        case (step)
          3'd0: touch = '{1'b0, nf, nk, 1'b0, mna_pkg::Q_ONE};
          3'd1: touch = '{1'b0, nt, nk, 1'b1, mna_pkg::Q_ONE};
          3'd2: touch = '{1'b0, nk, nk, 1'b0, mna_pkg::Q_ONE};
          default: touch = '{1'b1, nk, nk, 1'b0, val};
        endcase
      end
      mna_pkg::OP_RES: begin
        last_step = 3'd3;
        case (step)
          3'd0: touch = '{1'b0, nf, nf, 1'b0, gval};
          3'd1: touch = '{1'b0, nf, nt, 1'b1, gval};
          3'd2: touch = '{1'b0, nt, nf, 1'b1, gval};
          default: touch = '{1'b0, nt, nt, 1'b0, gval};
        endcase
      end
      default: begin
      end
    endcase
  end

  // Saturating read-modify-write of the touched entry.
  always_comb begin
    cur = touch.is_rhs ? rhs_rdata : mat_rdata;
    if (touch.sub) begin
      sum = {cur[mna_pkg::DATA_W-1], cur} -
            {touch.delta[mna_pkg::DATA_W-1], touch.delta};
    end else begin
      sum = {cur[mna_pkg::DATA_W-1], cur} +
            {touch.delta[mna_pkg::DATA_W-1], touch.delta};
    end
    ovf = sum[mna_pkg::DATA_W] ^ sum[mna_pkg::DATA_W-1];
    if (ovf) begin
      upd = sum[mna_pkg::DATA_W] ? mna_pkg::Q_MIN : mna_pkg::Q_MAX;
    end else begin
      upd = sum[mna_pkg::DATA_W-1:0];
    end
  end

  // Memory ports. The clear sweep writes zeros over both stores at once.
  always_comb begin
    wdata     = (state == S_CLR) ? '0 : upd;
    mat_we    = (state == S_CLR) || (state == S_WR && !is_read && !touch.is_rhs);
    rhs_we    = (state == S_CLR && clr_cnt[mna_pkg::ADDR_W-1:mna_pkg::IDX_W] == '0) ||
                (state == S_WR && !is_read && touch.is_rhs);
    mat_waddr = (state == S_CLR) ? clr_cnt : {touch.row, touch.col};
    rhs_waddr = (state == S_CLR) ? clr_cnt[mna_pkg::IDX_W-1:0] : touch.row;
    mat_raddr = is_read ? {rrow, rcol} : {touch.row, touch.col};
    rhs_raddr = is_read ? rrow : touch.row;
  end

  assign recip_start = s_acc && (in_op == mna_pkg::OP_RES) && (in_value != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      clr_item <= 1'b0;
      m_tvalid <= 1'b0;
      step     <= '0;
    end else begin
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == '1) begin
            state <= clr_item ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_acc) begin
            op       <= in_op;
            nf       <= s_tdata[8:3];
            nt       <= s_tdata[14:9];
            nk       <= s_tdata[20:15];
            val      <= in_value;
            rrow     <= s_tdata[90:85];
            rcol     <= s_tdata[96:91];
            step     <= '0;
            sat      <= 1'b0;
            zero_res <= (in_op == mna_pkg::OP_RES) && (in_value == '0);
            gval     <= mna_pkg::Q_MAX;
            clr_item <= 1'b1;
            clr_cnt  <= '0;
            unique case (in_op)
              mna_pkg::OP_CLEAR: state <= S_CLR;
              mna_pkg::OP_RES:   state <= (in_value == '0) ? S_RD : S_DIV;
              default:           state <= S_RD;
            endcase
          end
        end
        S_DIV: begin
          if (recip.done) begin
            gval  <= recip.g;
            sat   <= recip.sat;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_WR;
        end
        S_WR: begin
          if (is_read) begin
            state <= S_DONE;
          end else begin
            sat <= sat | ovf;
            if (step == last_step) begin
              state <= S_DONE;
            end else begin
              step  <= step + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result payload: no reset needed, loaded as each item finishes.
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      if (op == mna_pkg::OP_READ_M) begin
        rd_val <= mat_rdata;
      end else if (op == mna_pkg::OP_READ_R) begin
        rd_val <= rhs_rdata;
      end else begin
        rd_val <= '0;
      end
      if (op == mna_pkg::OP_CLEAR || is_read) begin
        status <= mna_pkg::ST_OK;
      end else if (zero_res) begin
        status <= mna_pkg::ST_DIV0;
      end else begin
        status <= sat ? mna_pkg::ST_SAT : mna_pkg::ST_OK;
      end
    end
  end

  mna_recip u_recip (
    .clk   (clk),
    .rst   (rst),
    .start (recip_start),
    .value (in_value),
    .res   (recip)
  );

  mna_ram #(
    .WIDTH (mna_pkg::DATA_W),
    .DEPTH (mna_pkg::DIM * mna_pkg::DIM)
  ) u_mat (
    .clk   (clk),
    .we    (mat_we),
    .waddr (mat_waddr),
    .wdata (wdata),
    .raddr (mat_raddr),
    .rdata (mat_rdata)
  );

  mna_ram #(
    .WIDTH (mna_pkg::DATA_W),
    .DEPTH (mna_pkg::DIM)
  ) u_rhs (
    .clk   (clk),
    .we    (rhs_we),
    .waddr (rhs_waddr),
    .wdata (wdata),
    .raddr (rhs_raddr),
    .rdata (rhs_rdata)
  );

  // The reciprocal unit only reports while a resistor waits on it.
  `MNA_ASSERT_IMP(a_recip_done_in_div, clk, rst, recip.done, state == S_DIV, "early recip")
  // Memory writes happen only in the sweep or the write-back cycle.
  `MNA_ASSERT_IMP(a_we_phase, clk, rst, mat_we || rhs_we, state == S_CLR || state == S_WR, "bad we")
  // Every read cycle is followed directly by its write-back.
  `MNA_ASSERT_NXT(a_rd_then_wr, clk, rst, state == S_RD, state == S_WR, "read not followed by write")
  // The step counter never runs past the stamp's last touch.
  `MNA_ASSERT_IMP(a_step_bound, clk, rst, state == S_WR && !is_read, step <= last_step, "step overrun")

endmodule

`default_nettype wire

// File: rtl/core/mna_ram.sv
`default_nettype none

module mna_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/mna_recip.sv
`default_nettype none

// Computes 2^64 / |v| one quotient bit per cycle, then applies the sign and
// clamps to the signed Q32.32 range.
module mna_recip (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [mna_pkg::DATA_W-1:0] value,
  output mna_pkg::recip_res_t            res
);

  logic [mna_pkg::DATA_W-1:0] dvs;
  logic [mna_pkg::DATA_W:0]   rem;
  logic [mna_pkg::DATA_W-1:0] quo;
  logic [mna_pkg::CNT_W-1:0]  cnt;
  logic                       run;
  logic                       fin;
  logic                       neg;

  logic [mna_pkg::DATA_W:0]   trial;
  logic                       fits;
  logic [mna_pkg::DATA_W:0]   qc;
  logic                       is_one;
  logic                       sat;

  assign trial = {rem[mna_pkg::DATA_W-1:0], 1'b1};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        neg <= value[mna_pkg::DATA_W-1];
        dvs <= value[mna_pkg::DATA_W-1] ? (~value + 1'b1) : value;
        rem <= '0;
        quo <= '0;
        cnt <= '0;
        run <= 1'b1;
      end else if (run) begin
        rem <= fits ? (trial - {1'b0, dvs}) : trial;
        quo <= {quo[mna_pkg::DATA_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == '1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end

  // The division ran on 2^64-1; a remainder of divisor-1 means 2^64 divides
  // one further step.
  always_comb begin
    is_one = dvs == {{(mna_pkg::DATA_W-1){1'b0}}, 1'b1};
    qc = {1'b0, quo} +
         {{mna_pkg::DATA_W{1'b0}}, (rem[mna_pkg::DATA_W-1:0] == dvs - 1'b1)};
    if (neg) begin
      sat   = is_one || (qc > {1'b0, mna_pkg::Q_MIN});
      res.g = sat ? mna_pkg::Q_MIN : (~qc[mna_pkg::DATA_W-1:0] + 1'b1);
    end else begin
      sat   = is_one || (qc > {1'b0, mna_pkg::Q_MAX});
      res.g = sat ? mna_pkg::Q_MAX : qc[mna_pkg::DATA_W-1:0];
    end
    res.sat  = sat;
    res.done = fin;
  end

endmodule

`default_nettype wire

// File: tb/tb_mna_stamp_accumulator.sv
`default_nettype none

// Stream test of the MNA stamp accumulator. A local copy of the matrix and
// the right-hand-side vector predicts every result item, which is compared
// in order with what the block returns.
module tb_mna_stamp_accumulator;
  timeunit 1ns;
  timeprecision 1ps;

  import mna_pkg::*;

  localparam logic signed [63:0] S_MAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] S_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] S_ONE = 64'sh0000_0001_0000_0000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [103:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;

  mna_stamp_accumulator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // One expected result item: the entry read back and the status code.
  typedef struct {
    logic [63:0] read_value;
    logic [1:0]  status;
  } answer_t;

  answer_t answer_q[$];

  // Local copy of the store, indexed as {row, column} for the matrix.
  logic signed [63:0] mat_copy [0:4095];
  logic signed [63:0] rhs_copy [0:63];
  bit                 clipped;

  int  errors      = 0;
  int  items_sent  = 0;
  int  items_seen  = 0;
  int  sat_count   = 0;
  int  div0_count  = 0;
  int  clear_count = 0;
  int  hold_left   = 0;
  int  idle_left   = 0;
  bit  no_idle     = 1'b0;

  // Saturating add and subtract; clipped records that a bound was hit.
  function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      clipped = 1'b1;
      return s[64] ? S_MIN : S_MAX;
    end
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) begin
      clipped = 1'b1;
      return s[64] ? S_MIN : S_MAX;
    end
    return s[63:0];
  endfunction

  // Conductance 2^64 / v, truncated toward zero, clipped to the signed range.
  function automatic logic signed [63:0] conductance_of(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [64:0] quo;
    mag = v[63] ? (~v + 64'd1) : v;
    if (mag == 64'd1) begin
      clipped = 1'b1;
      return v[63] ? S_MIN : S_MAX;
    end
    quo = {1'b1, 64'd0} / {1'b0, mag};
    if (!v[63]) begin
      if (quo > {1'b0, S_MAX}) begin
        clipped = 1'b1;
        return S_MAX;
      end
      return quo[63:0];
    end
    return ~quo[63:0] + 64'd1;
  endfunction

  task automatic mat_add(input logic [5:0] r, input logic [5:0] c,
                         input logic signed [63:0] d);
    mat_copy[{r, c}] = add_clip(mat_copy[{r, c}], d);
  endtask

  task automatic mat_sub(input logic [5:0] r, input logic [5:0] c,
                         input logic signed [63:0] d);
    mat_copy[{r, c}] = sub_clip(mat_copy[{r, c}], d);
  endtask

  task automatic wipe_store();
    for (int i = 0; i < 4096; i++) mat_copy[i] = '0;
    for (int i = 0; i < 64; i++) rhs_copy[i] = '0;
  endtask

  // Applies one accepted item to the local store and queues its answer.
  // The touches happen in the same order as in the block, so coinciding
  // entries are updated several times.
  task automatic apply_stamp(input op_t op, input logic [5:0] f, input logic [5:0] t,
                             input logic [5:0] k, input logic signed [63:0] v,
                             input logic [5:0] rr, input logic [5:0] rc);
    answer_t a;
    logic signed [63:0] g;
    a.read_value = '0;
    a.status     = ST_OK;
    clipped      = 1'b0;
    case (op)
      OP_CLEAR: begin
        wipe_store();
        clear_count++;
      end
      OP_VSRC: begin
        mat_add(f, k, S_ONE);
        mat_sub(t, k, S_ONE);
        mat_add(k, f, S_ONE);
        mat_sub(k, t, S_ONE);
        rhs_copy[k] = add_clip(rhs_copy[k], v);
      end
      OP_ISRC: begin
        rhs_copy[f] = sub_clip(rhs_copy[f], v);
        rhs_copy[t] = add_clip(rhs_copy[t], v);
      end
      OP_IBR: begin
        mat_add(f, k, S_ONE);
        mat_sub(t, k, S_ONE);
        mat_add(k, k, S_ONE);
        rhs_copy[k] = add_clip(rhs_copy[k], v);
      end
      OP_RES: begin
        // A zero resistance still stamps the largest conductance.
        g = (v == 0) ? S_MAX : conductance_of(v);
        mat_add(f, f, g);
        mat_sub(f, t, g);
        mat_sub(t, f, g);
        mat_add(t, t, g);
      end
      OP_RBR: begin
        mat_add(f, k, S_ONE);
        mat_sub(t, k, S_ONE);
        mat_add(k, f, S_ONE);
        mat_sub(k, t, S_ONE);
        mat_sub(k, k, v);
      end
      OP_READ_M: a.read_value = mat_copy[{rr, rc}];
      default:   a.read_value = rhs_copy[rr];
    endcase
    if (op == OP_RES && v == 0) a.status = ST_DIV0;
    else if (clipped && op != OP_CLEAR && op != OP_READ_M && op != OP_READ_R)
      a.status = ST_SAT;
    if (a.status == ST_SAT) sat_count++;
    if (a.status == ST_DIV0) div0_count++;
    answer_q = {answer_q, a};
  endtask

  // Idle lengths: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Offers one item from the falling edge on, holding it until accepted.
  // The prediction is made at the very edge where the handshake completes.
  task automatic send_item(input op_t op, input logic [5:0] f, input logic [5:0] t,
                           input logic [5:0] k, input logic [63:0] v,
                           input logic [5:0] rr, input logic [5:0] rc);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata  = {7'd0, rc, rr, v, k, t, f, op};
    do @(posedge clk); while (!s_tready);
    apply_stamp(op, f, t, k, v, rr, rc);
    items_sent++;
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      m_tready = 1'b0;
    end else if (idle_left > 0) begin
      idle_left--;
      m_tready = 1'b0;
    end else begin
      m_tready = 1'b1;
      if (!no_idle && $urandom_range(0, 3) == 0) idle_left = pick_gap();
    end
  end

  // Result checker: every accepted result item is matched with the oldest answer.
  always @(posedge clk) begin
    answer_t a;
    if (!rst && m_tvalid && m_tready) begin
      items_seen++;
      if (answer_q.size() == 0) begin
        $error("result item with no expectation: %h", m_tdata);
        errors++;
      end else begin
        a = answer_q.pop_front();
        if (m_tdata[63:0] !== a.read_value) begin
          $error("read_value expected %h actual %h", a.read_value, m_tdata[63:0]);
          errors++;
        end
        if (m_tdata[65:64] !== a.status) begin
          $error("status expected %0d actual %0d", a.status, m_tdata[65:64]);
          errors++;
        end
      end
    end
  end

  // Random node index: usually a small circuit so that entries collide.
  function automatic logic [5:0] pick_node();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 7);
    return $urandom_range(0, 63);
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return $urandom_range(0, 1) ? 64'd1 : '1;
      2:       return $urandom_range(0, 1) ? S_MAX : S_MIN;
      3:       return raw;
      4:       return $urandom_range(0, 1) ? 64'd2 : -64'sd2;
      default: return $signed(raw) >>> $urandom_range(16, 60);
    endcase
  endfunction

  task automatic wait_drained();
    @(negedge clk);
    s_tvalid = 1'b0;
    wait (answer_q.size() == 0);
    @(posedge clk);
  endtask

  // Extremes of every field, every op, zero resistance, the smallest resistance,
  // coinciding nodes and saturation of both the matrix and the vector.
  task automatic test_directed();
    send_item(OP_READ_M, 0, 0, 0, 0, 63, 63);
    send_item(OP_VSRC, 1, 2, 3, 64'h0000_0005_0000_0000, 0, 0);
    send_item(OP_ISRC, 63, 0, 0, S_MIN, 0, 0);
    send_item(OP_IBR, 2, 2, 2, 64'hffff_ffff_8000_0000, 0, 0);
    send_item(OP_RES, 1, 2, 0, 64'd0, 0, 0);
    send_item(OP_RES, 1, 2, 0, 64'd1, 0, 0);
    send_item(OP_RES, 4, 4, 0, '1, 0, 0);
    send_item(OP_RES, 5, 6, 0, S_MIN, 0, 0);
    send_item(OP_RES, 5, 6, 0, 64'd2, 0, 0);
    send_item(OP_RES, 7, 0, 0, S_MAX, 0, 0);
    send_item(OP_RBR, 0, 63, 63, S_MAX, 0, 0);
    send_item(OP_RBR, 0, 63, 63, S_MAX, 0, 0);
    send_item(OP_ISRC, 9, 10, 0, S_MAX, 0, 0);
    send_item(OP_ISRC, 9, 10, 0, S_MAX, 0, 0);
    send_item(OP_READ_M, 0, 0, 0, 0, 1, 1);
    send_item(OP_READ_M, 0, 0, 0, 0, 63, 63);
    send_item(OP_READ_M, 0, 0, 0, 0, 3, 1);
    send_item(OP_READ_M, 0, 0, 0, 0, 2, 2);
    send_item(OP_READ_R, 0, 0, 0, 0, 63, 0);
    send_item(OP_READ_R, 0, 0, 0, 0, 9, 0);
    send_item(OP_READ_R, 0, 0, 0, 0, 10, 63);
    send_item(OP_READ_R, 63, 63, 63, '1, 3, 63);
    send_item(OP_CLEAR, 63, 63, 63, '1, 63, 63);
    send_item(OP_READ_M, 0, 0, 0, 0, 1, 1);
  endtask

  // Random stamps interleaved with reads of the same small node set.
  task automatic test_random_mix(input int count);
    op_t op;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 6) op = op_t'($urandom_range(OP_VSRC, OP_RBR));
      else op = $urandom_range(0, 1) ? OP_READ_M : OP_READ_R;
      send_item(op, pick_node(), pick_node(), pick_node(), pick_value(),
                pick_node(), pick_node());
    end
  endtask

  // The receiver holds off for a long time while items keep coming, so the
  // output register fills and the input side has to stall.
  task automatic test_backpressure();
    @(negedge clk);
    hold_left = 500;
    test_random_mix(60);
  endtask

  // Clears in the middle of a run, after a full pause of the sender.
  task automatic test_clear_phase();
    wait_drained();
    send_item(OP_CLEAR, pick_node(), pick_node(), pick_node(), pick_value(), 0, 0);
    test_random_mix(300);
  endtask

  initial begin
    wipe_store();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random_mix(700);
    test_backpressure();
    test_clear_phase();
    test_random_mix(400);
    no_idle = 1'b1;
    test_random_mix(300);
    no_idle = 1'b0;
    wait_drained();
    repeat (50) @(posedge clk);
    $display("Sent %0d items, checked %0d results, %0d clears.",
             items_sent, items_seen, clear_count);
    $display("Saturated stamps: %0d, zero-resistance stamps: %0d.",
             sat_count, div0_count);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("tb_mna_stamp_accumulator OK");
    end else begin
      $display("tb_mna_stamp_accumulator NOT OK");
    end
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_mna_stamp_accumulator NOT OK");
    $finish;
  end

endmodule

`default_nettype wire

// File: mna_stamp_accumulator.f
+incdir+rtl/core
rtl/core/mna_pkg.sv
rtl/core/mna_ram.sv
rtl/core/mna_recip.sv
rtl/core/mna_stamp_accumulator.sv
tb/tb_mna_stamp_accumulator.sv
